FILE: hdl/sdu_pkg.sv
// ----------------------------------------------------------------------------
// SysEx dump unpacker package
// Shared types, byte codes and result kinds.
// ----------------------------------------------------------------------------
package sdu_pkg;

    localparam logic [7:0]  SYX_START     = 8'hF0;
    localparam logic [7:0]  SYX_END       = 8'hF7;
    localparam logic [7:0]  SYX_ZERO      = 8'h00;
    localparam logic [7:0]  SYX_MAKER     = 8'h0E;
    localparam logic [7:0]  SYX_MODEL     = 8'h00;
    localparam logic [15:0] MAX_BYTES_RST = 16'd64266;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_HDR1 = 3'd1,
        PH_HDR2 = 3'd2,
        PH_HDR3 = 3'd3,
        PH_HDR4 = 3'd4,
        PH_DATA = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        KIND_DATA  = 3'd0,
        KIND_DONE  = 3'd1,
        KIND_EMPTY = 3'd2,
        KIND_BADHD = 3'd3,
        KIND_LONG  = 3'd4
    } t_kind;

    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic [7:0]  out_byte;
        logic [15:0] byte_index;
    } t_result;

endpackage

FILE: hdl/sysex_dump_unpacker_unit.sv
// ----------------------------------------------------------------------------
// SysEx dump unpacker unit
// Checks the dump header and unpacks the 7-bit payload into 8-bit bytes.
// ----------------------------------------------------------------------------
//  channel  | valid       | stall       | payload
//  rx       | i_rx_valid  | o_rx_stall  | i_rx_byte
//  result   | o_res_valid | i_res_stall | o_kind, o_out_byte, o_byte_index
//  config   | i_cfg_we    | -           | i_cfg_data (max_bytes)
//
// One word per cycle while rx is not stalled; each result is registered.
// Input register, core logic and output register form the path; the output
// register has a skid entry, and rx stalls only while that entry is full.
// Synchronous active-low reset clears the dump state and sets max_bytes
// to 64266.
// ----------------------------------------------------------------------------
module sysex_dump_unpacker_unit
    import sdu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    output logic        o_res_valid,
    input  logic        i_res_stall,
    output t_kind       o_kind,
    output logic [7:0]  o_out_byte,
    output logic [15:0] o_byte_index
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic [15:0] r_max_bytes;
    logic        w_full;
    logic        w_go;
    t_result     w_res;

    assign w_go       = r_in_valid && !w_full;
    assign o_rx_stall = r_in_valid && w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_max_bytes <= MAX_BYTES_RST;
        end else begin
            if (i_cfg_we) begin
                r_max_bytes <= i_cfg_data;
            end
            if (!o_rx_stall) begin
                r_in_valid <= i_rx_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_rx_stall && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    sdu_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (w_go),
        .i_byte      (r_in_byte),
        .i_max_bytes (r_max_bytes),
        .o_res       (w_res)
    );

    sdu_outbuf u_outbuf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_res        (w_res),
        .o_full       (w_full),
        .o_res_valid  (o_res_valid),
        .i_res_stall  (i_res_stall),
        .o_kind       (o_kind),
        .o_out_byte   (o_out_byte),
        .o_byte_index (o_byte_index)
    );

`ifndef NO_ASSERTIONS
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rx_stall |-> o_res_valid)
        else $error("rx stalled with no result waiting");

    a_byte_only_for_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_kind != KIND_DATA) |-> o_out_byte == 8'd0)
        else $error("non-data result carries a byte");

    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_kind == KIND_EMPTY || o_kind == KIND_BADHD))
            |-> o_byte_index == 16'd0)
        else $error("empty or bad header result carries an index");

    a_done_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_kind == KIND_DONE) |-> o_byte_index != 16'd0)
        else $error("done result with zero count");
`endif

endmodule

FILE: hdl/sdu_core.sv
// ----------------------------------------------------------------------------
// SysEx dump unpacker core
// Header check, 7-to-8 bit unpacking and dump state, one word per cycle while i_go is set.
// ----------------------------------------------------------------------------
module sdu_core
    import sdu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [7:0]  i_byte,
    input  logic [15:0] i_max_bytes,
    output t_result     o_res
);

    t_phase      r_phase,      n_phase;
    logic [2:0]  r_group_pos,  n_group_pos;
    logic [7:0]  r_prev_byte,  n_prev_byte;
    logic [15:0] r_byte_count, n_byte_count;

    logic [7:0]  w_hi;
    logic [7:0]  w_lo;

    assign w_hi = r_prev_byte << r_group_pos;
    assign w_lo = i_byte >> (3'd7 - r_group_pos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_group_pos  <= 3'd0;
            r_prev_byte  <= 8'd0;
            r_byte_count <= 16'd0;
        end else begin
            r_phase      <= n_phase;
            r_group_pos  <= n_group_pos;
            r_prev_byte  <= n_prev_byte;
            r_byte_count <= n_byte_count;
        end
    end

    always_comb begin
        n_phase          = r_phase;
        n_group_pos      = r_group_pos;
        n_prev_byte      = r_prev_byte;
        n_byte_count     = r_byte_count;
        o_res.valid      = 1'b0;
        o_res.kind       = KIND_DATA;
        o_res.out_byte   = 8'd0;
        o_res.byte_index = 16'd0;
        if (i_go) begin
            unique case (r_phase)
                PH_HDR1, PH_HDR2: begin
                    if (i_byte != SYX_ZERO) begin
                        n_phase    = PH_IDLE;
                        o_res.valid = 1'b1;
                        o_res.kind  = KIND_BADHD;
                    end else begin
                        n_phase = (r_phase == PH_HDR1) ? PH_HDR2 : PH_HDR3;
                    end
                end
                PH_HDR3: begin
                    if (i_byte != SYX_MAKER) begin
                        n_phase    = PH_IDLE;
                        o_res.valid = 1'b1;
                        o_res.kind  = KIND_BADHD;
                    end else begin
                        n_phase = PH_HDR4;
                    end
                end
                PH_HDR4: begin
                    if (i_byte != SYX_MODEL) begin
                        n_phase    = PH_IDLE;
                        o_res.valid = 1'b1;
                        o_res.kind  = KIND_BADHD;
                    end else begin
                        n_phase      = PH_DATA;
                        n_group_pos  = 3'd0;
                        n_prev_byte  = 8'd0;
                        n_byte_count = 16'd0;
                    end
                end
                PH_DATA: begin
                    if (i_byte == SYX_END) begin
                        n_phase     = PH_IDLE;
                        o_res.valid = 1'b1;
                        if (r_byte_count == 16'd0) begin
                            o_res.kind = KIND_EMPTY;
                        end else begin
                            o_res.kind       = KIND_DONE;
                            o_res.byte_index = r_byte_count;
                        end
                    end else if (r_group_pos == 3'd0) begin
                        n_prev_byte = i_byte;
                        n_group_pos = 3'd1;
                    end else if (r_byte_count >= i_max_bytes) begin
                        n_phase          = PH_IDLE;
                        o_res.valid      = 1'b1;
                        o_res.kind       = KIND_LONG;
                        o_res.byte_index = r_byte_count;
                    end else begin
                        o_res.valid      = 1'b1;
                        o_res.kind       = KIND_DATA;
                        o_res.out_byte   = w_hi | w_lo;
                        o_res.byte_index = r_byte_count;
                        n_byte_count     = r_byte_count + 16'd1;
                        n_prev_byte      = i_byte;
                        n_group_pos      = r_group_pos + 3'd1;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    if (i_byte == SYX_START) begin
                        n_phase = PH_HDR1;
                    end else begin
                        o_res.valid = 1'b1;
                        o_res.kind  = KIND_BADHD;
                    end
                end
            endcase
        end
    end

endmodule

FILE: hdl/sdu_outbuf.sv
// ----------------------------------------------------------------------------
// SysEx dump unpacker output buffer
// Output register with a skid entry; takes one result while another waits.
// ----------------------------------------------------------------------------
module sdu_outbuf
    import sdu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_result     i_res,
    output logic        o_full,
    output logic        o_res_valid,
    input  logic        i_res_stall,
    output t_kind       o_kind,
    output logic [7:0]  o_out_byte,
    output logic [15:0] o_byte_index
);

    t_result r_out;
    t_result r_skid;
    logic    w_pop;

    assign w_pop = r_out.valid && !i_res_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid  <= 1'b0;
            r_skid.valid <= 1'b0;
        end else if (r_skid.valid) begin
            if (w_pop) begin
                r_out        <= r_skid;
                r_skid.valid <= 1'b0;
            end
        end else if (i_res.valid) begin
            if (!r_out.valid || w_pop) begin
                r_out <= i_res;
            end else begin
                r_skid <= i_res;
            end
        end else if (w_pop) begin
            r_out.valid <= 1'b0;
        end
    end

    assign o_full       = r_skid.valid;
    assign o_res_valid  = r_out.valid;
    assign o_kind       = r_out.kind;
    assign o_out_byte   = r_out.out_byte;
    assign o_byte_index = r_out.byte_index;

endmodule

FILE: verif/sdu_unpack_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SysEx unpack checker
// Watches the rx, result and config ports of the unpacker, predicts every
// result from the accepted rx words and compares each accepted result with
// the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module sdu_unpack_checker
    import sdu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    input  logic        i_rx_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_res_valid,
    input  logic        i_res_stall,
    input  t_kind       i_kind,
    input  logic [7:0]  i_out_byte,
    input  logic [15:0] i_byte_index,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  out_byte;
        logic [15:0] byte_index;
    } t_unpack_result;

    localparam logic [7:0] HDR_TAIL [1:4] =
        '{SYX_ZERO, SYX_ZERO, SYX_MAKER, SYX_MODEL};

    t_phase         dump_phase;
    logic [2:0]     group_pos;
    logic [7:0]     prev_byte;
    logic [15:0]    byte_count;
    logic [15:0]    max_bytes;
    t_unpack_result expected_results [$];

    task automatic push_result(input t_kind kind, input logic [7:0] ob,
                               input logic [15:0] idx);
        t_unpack_result r;
        r.kind       = kind;
        r.out_byte   = ob;
        r.byte_index = idx;
        expected_results.push_back(r);
    endtask

    task automatic unpack_rx_word(input logic [7:0] b);
        case (dump_phase)
            PH_HDR1, PH_HDR2, PH_HDR3, PH_HDR4: begin
                if (b != HDR_TAIL[dump_phase]) begin
                    dump_phase = PH_IDLE;
                    push_result(KIND_BADHD, 8'd0, 16'd0);
                end else begin
                    dump_phase = t_phase'(dump_phase + 3'd1);
                    if (dump_phase == PH_DATA) begin
                        group_pos  = 3'd0;
                        prev_byte  = 8'd0;
                        byte_count = 16'd0;
                    end
                end
            end
            PH_DATA: begin
                if (b == SYX_END) begin
                    dump_phase = PH_IDLE;
                    if (byte_count == 16'd0)
                        push_result(KIND_EMPTY, 8'd0, 16'd0);
                    else
                        push_result(KIND_DONE, 8'd0, byte_count);
                end else if (group_pos == 3'd0) begin
                    prev_byte = b;
                    group_pos = 3'd1;
                end else if (byte_count >= max_bytes) begin
                    dump_phase = PH_IDLE;
                    push_result(KIND_LONG, 8'd0, byte_count);
                end else begin
                    push_result(KIND_DATA,
                                (prev_byte << group_pos) | (b >> (3'd7 - group_pos)),
                                byte_count);
                    byte_count = byte_count + 16'd1;
                    prev_byte  = b;
                    group_pos  = group_pos + 3'd1;
                end
            end
            default: begin
                if (b == SYX_START) begin
                    dump_phase = PH_HDR1;
                end else begin
                    dump_phase = PH_IDLE;
                    push_result(KIND_BADHD, 8'd0, 16'd0);
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            o_errors++;
            $display("%0t: %s mismatch, expected %0d (0x%0h), got %0d (0x%0h)",
                     $time, name, want, want, got, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_unpack_result want;
        if (!i_rst_n) begin
            dump_phase = PH_IDLE;
            group_pos  = 3'd0;
            prev_byte  = 8'd0;
            byte_count = 16'd0;
            max_bytes  = MAX_BYTES_RST;
            o_errors   = 0;
            expected_results.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (expected_results.size() == 0) begin
                    o_errors++;
                    $display({"%0t: unexpected result, expected none, ",
                              "got kind %0d byte 0x%02h index %0d"},
                             $time, i_kind, i_out_byte, i_byte_index);
                end else begin
                    want = expected_results.pop_front();
                    check_field("kind", want.kind, i_kind);
                    check_field("out_byte", want.out_byte, i_out_byte);
                    check_field("byte_index", want.byte_index, i_byte_index);
                end
            end
            if (i_cfg_we)
                max_bytes = i_cfg_data;
            if (i_rx_valid && !i_rx_stall)
                unpack_rx_word(i_rx_byte);
        end
        o_pending = expected_results.size();
    end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SysEx dump unpacker testbench
// Drives directed and random dumps (good, broken and noisy) into the unpacker
// under several max_bytes settings and idling mixes; the checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb
    import sdu_pkg::*;
();

    localparam int WORDS_PER_SEGMENT = 220;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_rx_valid  = 1'b0;
    logic [7:0]  i_rx_byte   = 8'd0;
    logic        i_cfg_we    = 1'b0;
    logic [15:0] i_cfg_data  = 16'd0;
    logic        i_res_stall = 1'b0;
    logic        o_rx_stall;
    logic        o_res_valid;
    t_kind       o_kind;
    logic [7:0]  o_out_byte;
    logic [15:0] o_byte_index;

    int errors;
    int pending;
    int send_idle_pct = 24;
    int recv_idle_pct = 86;
    int words_sent    = 0;
    int hold_asks     = 0;
    int holds_given   = 0;
    int hold_left     = 0;

    always #5 i_clk = ~i_clk;

    sysex_dump_unpacker_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx_valid   (i_rx_valid),
        .o_rx_stall   (o_rx_stall),
        .i_rx_byte    (i_rx_byte),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_res_valid  (o_res_valid),
        .i_res_stall  (i_res_stall),
        .o_kind       (o_kind),
        .o_out_byte   (o_out_byte),
        .o_byte_index (o_byte_index)
    );

    sdu_unpack_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx_valid   (i_rx_valid),
        .i_rx_stall   (o_rx_stall),
        .i_rx_byte    (i_rx_byte),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_res_valid  (o_res_valid),
        .i_res_stall  (i_res_stall),
        .i_kind       (o_kind),
        .i_out_byte   (o_out_byte),
        .i_byte_index (o_byte_index),
        .o_errors     (errors),
        .o_pending    (pending)
    );

    // hold off for a long stretch on request, else stall at random
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left--;
            i_res_stall <= 1'b1;
        end else if (holds_given != hold_asks) begin
            holds_given++;
            hold_left = 80;
            i_res_stall <= 1'b1;
        end else begin
            i_res_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic send_word(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_rx_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_rx_stall);
        @(negedge i_clk);
        words_sent++;
    endtask

    task automatic send_dump(input int n_data, input bit seven_bit, input int bad_pos,
                             input bit with_eox);
        logic [7:0] hdr [5];
        logic [7:0] b;
        hdr = '{SYX_START, SYX_ZERO, SYX_ZERO, SYX_MAKER, SYX_MODEL};
        for (int i = 0; i < 5; i++) begin
            b = hdr[i];
            if (i == bad_pos) begin
                send_word(b ^ 8'($urandom_range(1, 255)));
                return;
            end
            send_word(b);
        end
        for (int i = 0; i < n_data; i++) begin
            b = seven_bit ? 8'($urandom_range(127)) : 8'($urandom_range(255));
            send_word(b);
        end
        if (with_eox)
            send_word(SYX_END);
    endtask

    task automatic drain();
        i_rx_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_max_bytes(input logic [15:0] value);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic random_traffic(input int target);
        int pick;
        int n;
        while (words_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                n = ($urandom_range(19) == 0) ? $urandom_range(70) : $urandom_range(30);
                send_dump(n, $urandom_range(9) != 0, -1, $urandom_range(15) != 0);
            end else if (pick < 88) begin
                send_dump(0, 1'b1, $urandom_range(4), 1'b1);
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) send_word(8'($urandom_range(255)));
            end
        end
    endtask

    initial begin
        logic [15:0] max_plan [5];
        max_plan = '{16'd1, 16'($urandom_range(2, 40)), 16'd0,
                     16'($urandom_range(65535)), 16'd65535};
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_word(8'h00);
        send_word(8'hFF);
        send_dump(0, 1'b1, -1, 1'b1);
        send_dump(0, 1'b1, 3, 1'b1);
        send_dump(0, 1'b1, 1, 1'b1);
        send_dump(0, 1'b1, -1, 1'b0);
        send_word(8'h7F);
        send_word(8'h00);
        send_word(8'hFF);
        send_word(8'h80);
        send_word(8'h55);
        send_word(8'h2A);
        send_word(8'h7F);
        send_word(8'h01);
        send_word(SYX_END);

        for (int seg = 0; seg < 5; seg++) begin
            write_max_bytes(max_plan[seg]);
            if (seg < 2) begin
                send_idle_pct = 24;
                recv_idle_pct = 86;
            end else if (seg < 4) begin
                send_idle_pct = 86;
                recv_idle_pct = 24;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_asks <= hold_asks + 1;
                send_dump(60, 1'b1, -1, 1'b1);
            end
            random_traffic(words_sent + WORDS_PER_SEGMENT);
        end

        drain();
        repeat (8) @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
